/* rtl/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared constants, types and helpers for the toroidal Life generation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlg_pkg;

	localparam int GRID_WIDTH  = 80;
	localparam int GRID_HEIGHT = 25;

	localparam int ROW_AW  = $clog2(GRID_HEIGHT);
	localparam int COL_AW  = $clog2(GRID_WIDTH);
	localparam int COUNT_W = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
	localparam int POP_W   = 11;
	localparam int POP_MAX = (1 << POP_W) - 1;

	typedef logic [GRID_WIDTH-1:0] row_bits_t;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_STEP  = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CELL,
		ST_GEN_PREV,
		ST_GEN_CUR,
		ST_GEN_NEXT,
		ST_GEN_CALC,
		ST_GEN_WRITE,
		ST_RESULT
	} state_t;

	// row held so that bit 0 is the west neighbour of column 0
	function automatic row_bits_t rot_west(input row_bits_t r);
		return {r[GRID_WIDTH-2:0], r[GRID_WIDTH-1]};
	endfunction

	function automatic logic next_cell(input logic [2:0] north, input logic [2:0] mid,
			input logic [2:0] south);
		logic [3:0] sum;
		sum = 4'(north[0]) + 4'(north[1]) + 4'(north[2])
			+ 4'(mid[0]) + 4'(mid[1]) + 4'(mid[2])
			+ 4'(south[0]) + 4'(south[1]) + 4'(south[2]);
		return (sum == 4'd3) || (mid[1] && (sum == 4'd4));
	endfunction

endpackage

`default_nettype wire

/* rtl/tlg_ram.sv */
// ----------------------------------------------------------------------------
// tlg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/toroidal_life_generation.sv */
// ----------------------------------------------------------------------------
// toroidal_life_generation
// Toroidal B3/S23 Life grid: cell write, cell read and whole-grid generation.
// ----------------------------------------------------------------------------
//  channel   dir  tdata bits (low first)                        tuser/tlast
//  s_axis    in   func[1:0] row[6:2] col[13:7] cell_in[14] pad  -
//  m_axis    out  cell_out[0] population[11:1] pad              -
//
//  Cell write/read: decode, then a row read-modify-write, then the result.
//  Generation: one cell per cycle within a row, through the shared 3x3
//  next-state unit over a three-row window; each finished row is written back.
//  Grid rows live in a row-wide RAM; per-row valid flops make unwritten rows
//  read dead, so reset takes effect at once with no clearing pass.
//  Input is not ready while an item is at work; one result may wait in the
//  output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_life_generation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // func, row, col, cell_in
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata   // cell_out, population
);

	localparam int W = tlg_pkg::GRID_WIDTH;
	localparam int H = tlg_pkg::GRID_HEIGHT;
	localparam int RA = tlg_pkg::ROW_AW;
	localparam int CA = tlg_pkg::COL_AW;
	localparam int CW = tlg_pkg::COUNT_W;
	localparam int PW = tlg_pkg::POP_W;

	tlg_pkg::state_t state_q, state_d;

	logic [1:0] func_q;
	logic [4:0] row_q;
	logic [6:0] col_q;
	logic       val_q;

	logic [CW-1:0] live_q;
	logic [CW-1:0] gen_cnt_q;
	logic          cell_res_q;

	logic [RA-1:0] row_cnt_q;
	logic [CA-1:0] col_cnt_q;

	tlg_pkg::row_bits_t prev_q, cur_q, nxt_q, row0_q, new_q;

	logic          mem_we, mem_re;
	logic [RA-1:0] mem_waddr, mem_raddr;
	tlg_pkg::row_bits_t mem_wdata, mem_rdata, rd_row, cell_wrow;
	logic          rd_ok_s1;
	logic [H-1:0]  row_valid_q;

	logic          in_range;
	logic          old_bit;
	logic          next_bit;
	logic [RA:0]   row_plus2;
	logic [PW-1:0] pop_sat;
	logic          out_load;

	tlg_ram #(
		.WIDTH(W),
		.DEPTH(H)
	) u_grid (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_range = (int'(row_q) < H) && (int'(col_q) < W);
	assign rd_row   = rd_ok_s1 ? mem_rdata : '0;
	assign old_bit  = rd_row[CA'(col_q)];
	assign next_bit = tlg_pkg::next_cell(prev_q[2:0], cur_q[2:0], nxt_q[2:0]);
	assign row_plus2 = {1'b0, row_cnt_q} + (RA+1)'(2);
	assign pop_sat  = (int'(live_q) > tlg_pkg::POP_MAX) ? PW'(tlg_pkg::POP_MAX) : PW'(live_q);

	always_comb begin
		cell_wrow = rd_row;
		cell_wrow[CA'(col_q)] = val_q;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = RA'(row_q);
		mem_wdata     = cell_wrow;
		mem_re        = 1'b0;
		mem_raddr     = RA'(row_q);
		out_load      = 1'b0;
		case (state_q)
			tlg_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = tlg_pkg::ST_DECODE;
				end
			end
			tlg_pkg::ST_DECODE: begin
				case (func_q)
					tlg_pkg::FUNC_WRITE, tlg_pkg::FUNC_READ: begin
						if (in_range) begin
							mem_re  = 1'b1;
							state_d = tlg_pkg::ST_CELL;
						end else begin
							state_d = tlg_pkg::ST_RESULT;
						end
					end
					tlg_pkg::FUNC_STEP: begin
						mem_re    = 1'b1;
						mem_raddr = RA'(H - 1);
						state_d   = tlg_pkg::ST_GEN_PREV;
					end
					default: state_d = tlg_pkg::ST_RESULT;
				endcase
			end
			tlg_pkg::ST_CELL: begin
				mem_we  = (func_q == tlg_pkg::FUNC_WRITE) && (old_bit != val_q);
				state_d = tlg_pkg::ST_RESULT;
			end
			tlg_pkg::ST_GEN_PREV: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
				state_d   = tlg_pkg::ST_GEN_CUR;
			end
			tlg_pkg::ST_GEN_CUR: begin
				mem_re    = 1'b1;
				mem_raddr = RA'(1);
				state_d   = tlg_pkg::ST_GEN_NEXT;
			end
			tlg_pkg::ST_GEN_NEXT: begin
				state_d = tlg_pkg::ST_GEN_CALC;
			end
			tlg_pkg::ST_GEN_CALC: begin
				if (int'(col_cnt_q) == W - 1) begin
					state_d = tlg_pkg::ST_GEN_WRITE;
				end
			end
			tlg_pkg::ST_GEN_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = row_cnt_q;
				mem_wdata = new_q;
				mem_raddr = row_plus2[RA-1:0];
				if (int'(row_cnt_q) == H - 1) begin
					state_d = tlg_pkg::ST_RESULT;
				end else begin
					mem_re  = int'(row_plus2) <= H - 1;
					state_d = tlg_pkg::ST_GEN_NEXT;
				end
			end
			tlg_pkg::ST_RESULT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = tlg_pkg::ST_IDLE;
				end
			end
			default: state_d = tlg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tlg_pkg::ST_IDLE;
			live_q        <= '0;
			row_valid_q   <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				row_valid_q[mem_waddr] <= 1'b1;
			end
			if (state_q == tlg_pkg::ST_CELL && mem_we) begin
				live_q <= val_q ? live_q + CW'(1) : live_q - CW'(1);
			end
			if (state_q == tlg_pkg::ST_GEN_WRITE && int'(row_cnt_q) == H - 1) begin
				live_q <= gen_cnt_q;
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_ok_s1 <= row_valid_q[mem_raddr];
		end
		if (out_load) begin
			m_axis_tdata <= {4'b0, pop_sat, cell_res_q};
		end
		case (state_q)
			tlg_pkg::ST_IDLE: begin
				func_q <= s_axis_tdata[1:0];
				row_q  <= s_axis_tdata[6:2];
				col_q  <= s_axis_tdata[13:7];
				val_q  <= s_axis_tdata[14];
			end
			tlg_pkg::ST_DECODE: begin
				cell_res_q <= 1'b0;
				row_cnt_q  <= '0;
			end
			tlg_pkg::ST_CELL: begin
				cell_res_q <= (func_q == tlg_pkg::FUNC_READ) && old_bit;
			end
			tlg_pkg::ST_GEN_PREV: begin
				prev_q    <= tlg_pkg::rot_west(rd_row);
				gen_cnt_q <= '0;
			end
			tlg_pkg::ST_GEN_CUR: begin
				cur_q  <= tlg_pkg::rot_west(rd_row);
				row0_q <= tlg_pkg::rot_west(rd_row);
			end
			tlg_pkg::ST_GEN_NEXT: begin
				nxt_q     <= (int'(row_cnt_q) == H - 1) ? row0_q : tlg_pkg::rot_west(rd_row);
				col_cnt_q <= '0;
			end
			tlg_pkg::ST_GEN_CALC: begin
				new_q     <= {next_bit, new_q[W-1:1]};
				prev_q    <= {prev_q[0], prev_q[W-1:1]};
				cur_q     <= {cur_q[0], cur_q[W-1:1]};
				nxt_q     <= {nxt_q[0], nxt_q[W-1:1]};
				gen_cnt_q <= gen_cnt_q + CW'(next_bit);
				col_cnt_q <= col_cnt_q + CA'(1);
			end
			tlg_pkg::ST_GEN_WRITE: begin
				prev_q    <= cur_q;
				cur_q     <= nxt_q;
				row_cnt_q <= row_cnt_q + RA'(1);
			end
			default: begin
			end
		endcase
	end

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == tlg_pkg::ST_CELL || state_q == tlg_pkg::ST_GEN_WRITE))
		else $error("grid written outside a write state");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(live_q) <= W * H)
		else $error("live count above grid size");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == tlg_pkg::ST_DECODE))
		else $error("transfer taken without starting work");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire
